// File: rtl/dlps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlps_pkg
// Shared types, codes and helpers of the delay/loss packet scheduler.
// ----------------------------------------------------------------------------
package dlps_pkg;

    localparam int unsigned RES_W       = 5;
    localparam logic [RES_W-1:0] MAX_RESULTS = 5'd16;
    localparam logic [15:0] LFSR_TAPS   = 16'hB400;
    localparam int unsigned CFG_IDX_W   = 4;

    typedef enum logic [1:0] {
        K_QUEUED  = 2'd0,
        K_REFUSED = 2'd1,
        K_SENT    = 2'd2,
        K_DROPPED = 2'd3
    } t_kind;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_LAT  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LAT  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOSS_THR = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SEED     = 4'd3;

    typedef struct packed {
        logic [31:0] deadline;
        logic [31:0] address;
        logic [15:0] port;
        logic [15:0] length;
        logic [15:0] handle;
    } t_entry;

    // one Galois step; state zero is treated as one
    function automatic logic [15:0] lfsr_step(input logic [15:0] s);
        logic [15:0] v;
        v = (s == 16'd0) ? 16'd1 : s;
        return v[0] ? ((v >> 1) ^ LFSR_TAPS) : (v >> 1);
    endfunction

endpackage

// File: rtl/dlps_mod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlps_mod
// Restoring 16-bit remainder unit, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dlps_mod (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [15:0] i_dividend,
    input  logic [15:0] i_divisor,
    output logic        o_done,
    output logic [15:0] o_rem
);
    logic        r_run;
    logic [4:0]  r_cnt;
    logic [15:0] r_rem;
    logic [15:0] r_dvd;
    logic [15:0] r_dvs;
    logic        r_done;
    logic [16:0] n_trial;

    always_comb begin
        n_trial = {r_rem, r_dvd[15]};
        if (n_trial >= {1'b0, r_dvs}) begin
            n_trial = n_trial - {1'b0, r_dvs};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 5'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= 5'd0;
                r_rem <= 16'd0;
                r_dvd <= i_dividend;
                r_dvs <= i_divisor;
            end else if (r_run) begin
                // partial remainder stays below the divisor, so 16 bits hold it
                r_rem <= n_trial[15:0];
                r_dvd <= {r_dvd[14:0], 1'b0};
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd15) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;
endmodule

// File: rtl/dlps_entry_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlps_entry_ram
// Descriptor store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module dlps_entry_ram #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = 4
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  dlps_pkg::t_entry i_wdata,
    input  logic [AW-1:0]   i_raddr,
    output dlps_pkg::t_entry o_rdata
);
    dlps_pkg::t_entry r_mem [DEPTH];
    dlps_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/delay_loss_packet_scheduler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delay_loss_packet_scheduler_top
// Queues packet descriptors with a jittered deadline and releases due ones
// on each tick, marking them sent or dropped.
// ----------------------------------------------------------------------------
//  channel  | handshake                | payload
//  ---------+--------------------------+-----------------------------------
//  command  | i_start / o_busy         | i_cmd, i_peer_*, i_packet_length,
//           |                          | i_payload_handle
//  result   | o_strobe (no back-press) | o_kind, o_out_*, o_bytes_sent_total,
//           |                          | o_last
//  config   | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
//  Queue: written directly, or through the serial 16-bit remainder unit when jitter is on.
//  Tick: each stored entry is one RAM read (S_RD) then evaluate (S_EV), then S_END.
//  Results go out one behind the scan, the last at scan end.
//  Config is taken only while idle with no start pending.
//  Reset is synchronous and needs no clearing pass; results cannot stall.
// ----------------------------------------------------------------------------
module delay_loss_packet_scheduler_top #(
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic        i_cmd,
    input  logic [31:0] i_peer_address,
    input  logic [15:0] i_peer_port,
    input  logic [15:0] i_packet_length,
    input  logic [15:0] i_payload_handle,
    output logic        o_strobe,
    output logic [1:0]  o_kind,
    output logic [31:0] o_out_address,
    output logic [15:0] o_out_port,
    output logic [15:0] o_out_length,
    output logic [15:0] o_out_handle,
    output logic [31:0] o_bytes_sent_total,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [dlps_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(QUEUE_DEPTH);

    typedef enum logic [2:0] {S_IDLE, S_DIV, S_RD, S_EV, S_END} t_state;

    t_state      r_state;
    logic [15:0] r_min, r_max, r_thr, r_lfsr;
    logic [31:0] r_time, r_bytes;
    logic [CW-1:0] r_count, r_idx, r_keep;
    logic [dlps_pkg::RES_W-1:0] r_n;
    dlps_pkg::t_entry r_desc;

    // held release, shown once the next one (or the scan end) is known
    logic        r_pend;
    dlps_pkg::t_kind r_pkind;
    dlps_pkg::t_entry r_pent;
    logic [31:0] r_pbytes;

    logic        r_ov, r_olast;
    dlps_pkg::t_kind r_okind;
    dlps_pkg::t_entry r_oent;
    logic [31:0] r_obytes;

    logic        div_start, div_done;
    logic [15:0] div_rem, n_sample;
    logic        mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    dlps_pkg::t_entry mem_wdata, mem_rdata;
    logic        jitter_on, due;
    logic [31:0] age;
    logic [31:0] n_bytes;

    assign jitter_on = r_max > r_min;
    assign n_sample  = dlps_pkg::lfsr_step(r_lfsr);
    // due when the wrapped age is non-negative
    assign age       = r_time - mem_rdata.deadline;
    assign due       = !age[31];
    assign n_bytes   = r_bytes + {16'd0, mem_rdata.length};

    assign div_start = (r_state == S_IDLE) && i_start && !i_cmd
                       && (r_count != FULL) && jitter_on;

    dlps_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (n_sample),
        .i_divisor  (r_max - r_min),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_count[AW-1:0];
        mem_wdata = r_desc;
        mem_raddr = r_idx[AW-1:0];
        if (r_state == S_IDLE && i_start && !i_cmd && r_count != FULL && !jitter_on) begin
            mem_we    = 1'b1;
            mem_wdata = '{deadline: r_time + {16'd0, r_min}, address: i_peer_address,
                          port: i_peer_port, length: i_packet_length,
                          handle: i_payload_handle};
        end else if (r_state == S_DIV && div_done) begin
            mem_we    = 1'b1;
            mem_wdata = r_desc;
            mem_wdata.deadline = r_time + {16'd0, r_min} + {16'd0, div_rem};
        end else if (r_state == S_EV && !(due && r_n < dlps_pkg::MAX_RESULTS)) begin
            mem_we    = 1'b1;
            mem_waddr = r_keep[AW-1:0];
            mem_wdata = mem_rdata;
        end
    end

    dlps_entry_ram #(.DEPTH(QUEUE_DEPTH), .AW(AW)) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_min   <= 16'd0;
            r_max   <= 16'd0;
            r_thr   <= 16'd0;
            r_lfsr  <= 16'd1;
            r_time  <= 32'd0;
            r_bytes <= 32'd0;
            r_count <= '0;
            r_idx   <= '0;
            r_keep  <= '0;
            r_n     <= '0;
            r_pend  <= 1'b0;
            r_ov    <= 1'b0;
            r_olast <= 1'b0;
        end else begin
            r_ov <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    dlps_pkg::REG_MIN_LAT:  r_min <= i_cfg_data;
                    dlps_pkg::REG_MAX_LAT:  r_max <= i_cfg_data;
                    dlps_pkg::REG_LOSS_THR: r_thr <= i_cfg_data;
                    dlps_pkg::REG_SEED:
                        r_lfsr <= (i_cfg_data == 16'd0) ? 16'd1 : i_cfg_data;
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_desc <= '{deadline: 32'd0, address: i_peer_address,
                                    port: i_peer_port, length: i_packet_length,
                                    handle: i_payload_handle};
                        if (i_cmd) begin
                            r_time  <= r_time + 32'd1;
                            r_idx   <= '0;
                            r_keep  <= '0;
                            r_n     <= '0;
                            r_pend  <= 1'b0;
                            r_state <= S_RD;
                        end else begin
                            r_oent <= '{deadline: 32'd0, address: i_peer_address,
                                        port: i_peer_port, length: i_packet_length,
                                        handle: i_payload_handle};
                            r_obytes <= r_bytes;
                            r_olast  <= 1'b1;
                            if (r_count == FULL) begin
                                r_ov    <= 1'b1;
                                r_okind <= dlps_pkg::K_REFUSED;
                            end else if (jitter_on) begin
                                r_lfsr  <= n_sample;
                                r_state <= S_DIV;
                            end else begin
                                r_ov    <= 1'b1;
                                r_okind <= dlps_pkg::K_QUEUED;
                                r_count <= r_count + CW'(1);
                            end
                        end
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_ov    <= 1'b1;
                        r_okind <= dlps_pkg::K_QUEUED;
                        r_count <= r_count + CW'(1);
                        r_state <= S_IDLE;
                    end
                end
                S_RD: begin
                    r_state <= (r_idx == r_count) ? S_END : S_EV;
                end
                S_EV: begin
                    if (due && r_n < dlps_pkg::MAX_RESULTS) begin
                        r_lfsr <= n_sample;
                        r_n    <= r_n + dlps_pkg::RES_W'(1);
                        if (r_pend) begin
                            r_ov     <= 1'b1;
                            r_olast  <= 1'b0;
                            r_okind  <= r_pkind;
                            r_oent   <= r_pent;
                            r_obytes <= r_pbytes;
                        end
                        r_pend <= 1'b1;
                        r_pent <= mem_rdata;
                        if (n_sample > r_thr) begin
                            r_pkind  <= dlps_pkg::K_SENT;
                            r_bytes  <= n_bytes;
                            r_pbytes <= n_bytes;
                        end else begin
                            r_pkind  <= dlps_pkg::K_DROPPED;
                            r_pbytes <= r_bytes;
                        end
                    end else begin
                        r_keep <= r_keep + CW'(1);
                    end
                    r_idx   <= r_idx + CW'(1);
                    r_state <= S_RD;
                end
                S_END: begin
                    r_count <= r_keep;
                    if (r_pend) begin
                        r_ov     <= 1'b1;
                        r_olast  <= 1'b1;
                        r_okind  <= r_pkind;
                        r_oent   <= r_pent;
                        r_obytes <= r_pbytes;
                    end
                    r_pend  <= 1'b0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy             = (r_state != S_IDLE);
    assign o_cfg_ready        = (r_state == S_IDLE) && !i_start;
    assign o_strobe           = r_ov;
    assign o_kind             = r_okind;
    assign o_out_address      = r_oent.address;
    assign o_out_port         = r_oent.port;
    assign o_out_length       = r_oent.length;
    assign o_out_handle       = r_oent.handle;
    assign o_bytes_sent_total = r_obytes;
    assign o_last             = r_olast;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL) else $error("entry count above queue depth");
    a_queue_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_kind == dlps_pkg::K_QUEUED || o_kind == dlps_pkg::K_REFUSED))
        |-> o_last) else $error("queue result without last");
    a_keep_le_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EV) |-> (r_keep <= r_idx)) else $error("compaction overtook scan");
    a_n_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= dlps_pkg::MAX_RESULTS) else $error("too many releases");
endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the delay/loss packet scheduler. A scoreboard class
// predicts queue, refuse and release results from its own copy of the queue,
// time, LFSR and byte counter, and checks every strobed result in order.
// ----------------------------------------------------------------------------
typedef struct {
    dlps_pkg::t_kind kind;
    logic [31:0] addr;
    logic [15:0] port;
    logic [15:0] len;
    logic [15:0] handle;
    logic [31:0] total;
    logic        last;
} t_release;

class release_scoreboard;
    localparam int DEPTH = 16;
    localparam int MAX_REL = 16;
    logic [15:0] min_lat, max_lat, loss_thr, lfsr;
    logic [31:0] dl[DEPTH], ad[DEPTH];
    logic [15:0] pt[DEPTH], ln[DEPTH], hd[DEPTH];
    int          count;
    logic [31:0] now, bytes;
    t_release    expected_q[$];
    int          errors;

    function new();
        min_lat = 0; max_lat = 0; loss_thr = 0; lfsr = 16'd1;
        count = 0; now = 0; bytes = 0; errors = 0;
    endfunction

    function logic [15:0] next_sample();
        logic [15:0] s;
        s = (lfsr == 16'd0) ? 16'd1 : lfsr;
        s = s[0] ? ((s >> 1) ^ 16'hB400) : (s >> 1);
        lfsr = s;
        return s;
    endfunction

    function void write_reg(logic [dlps_pkg::CFG_IDX_W-1:0] idx, logic [15:0] v);
        case (idx)
            dlps_pkg::REG_MIN_LAT:  min_lat = v;
            dlps_pkg::REG_MAX_LAT:  max_lat = v;
            dlps_pkg::REG_LOSS_THR: loss_thr = v;
            dlps_pkg::REG_SEED:     lfsr = (v == 16'd0) ? 16'd1 : v;
            default: ;
        endcase
    endfunction

    function void push(dlps_pkg::t_kind k, logic [31:0] a, logic [15:0] p,
                       logic [15:0] l, logic [15:0] h, logic lst);
        t_release r;
        r.kind = k; r.addr = a; r.port = p; r.len = l; r.handle = h;
        r.total = bytes; r.last = lst;
        expected_q = {expected_q, r};
    endfunction

    function void note_item(logic cmd, logic [31:0] a, logic [15:0] p, logic [15:0] l,
                            logic [15:0] h);
        logic [31:0] wait_t;
        logic [31:0] age;
        int          keep, n, first;
        dlps_pkg::t_kind k;
        if (cmd == 1'b0) begin
            if (count >= DEPTH) begin
                push(dlps_pkg::K_REFUSED, a, p, l, h, 1'b1);
                return;
            end
            wait_t = min_lat;
            if (max_lat > min_lat)
                wait_t += 32'(next_sample() % (max_lat - min_lat));
            dl[count] = now + wait_t; ad[count] = a; pt[count] = p;
            ln[count] = l; hd[count] = h;
            count++;
            push(dlps_pkg::K_QUEUED, a, p, l, h, 1'b1);
            return;
        end
        now += 1;
        keep = 0; n = 0;
        first = expected_q.size();
        for (int i = 0; i < count; i++) begin
            age = now - dl[i];
            if (!age[31] && n < MAX_REL) begin
                if (next_sample() > loss_thr) begin
                    bytes += 32'(ln[i]);
                    k = dlps_pkg::K_SENT;
                end else begin
                    k = dlps_pkg::K_DROPPED;
                end
                push(k, ad[i], pt[i], ln[i], hd[i], 1'b0);
                n++;
            end else begin
                dl[keep] = dl[i]; ad[keep] = ad[i]; pt[keep] = pt[i];
                ln[keep] = ln[i]; hd[keep] = hd[i];
                keep++;
            end
        end
        count = keep;
        if (n > 0)
            expected_q[first + n - 1].last = 1'b1;
    endfunction

    function void check_release(t_release got);
        t_release e;
        if (expected_q.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("unexpected result kind=%0d addr=%h", got.kind, got.addr);
            return;
        end
        e = expected_q.pop_front();
        if (got.kind !== e.kind || got.addr !== e.addr || got.port !== e.port ||
            got.len !== e.len || got.handle !== e.handle || got.total !== e.total ||
            got.last !== e.last) begin
            errors++;
            if (errors <= 10)
                $display("exp k=%0d a=%h p=%h l=%h h=%h t=%h last=%b / got k=%0d a=%h p=%h l=%h h=%h t=%h last=%b",
                         e.kind, e.addr, e.port, e.len, e.handle, e.total, e.last,
                         got.kind, got.addr, got.port, got.len, got.handle,
                         got.total, got.last);
        end
    endfunction
endclass

module tb_top;
    localparam int LIMIT = 600000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic        o_busy;
    logic        i_cmd = 1'b0;
    logic [31:0] i_peer_address = '0;
    logic [15:0] i_peer_port = '0;
    logic [15:0] i_packet_length = '0;
    logic [15:0] i_payload_handle = '0;
    logic        o_strobe;
    logic [1:0]  o_kind;
    logic [31:0] o_out_address;
    logic [15:0] o_out_port;
    logic [15:0] o_out_length;
    logic [15:0] o_out_handle;
    logic [31:0] o_bytes_sent_total;
    logic        o_last;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [dlps_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    release_scoreboard sb = new();
    int cycles = 0;
    int burst_left = 0;

    always #5 i_clk = ~i_clk;

    delay_loss_packet_scheduler_top u_dut (.*);

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("delay_loss_packet_scheduler_top: mismatch");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_release got;
        if (i_rst_n && o_strobe) begin
            got.kind = dlps_pkg::t_kind'(o_kind); got.addr = o_out_address;
            got.port = o_out_port; got.len = o_out_length;
            got.handle = o_out_handle; got.total = o_bytes_sent_total;
            got.last = o_last;
            sb.check_release(got);
        end
    end

    task automatic send_item(logic cmd, logic [31:0] a, logic [15:0] p, logic [15:0] l,
                             logic [15:0] h);
        @(negedge i_clk);
        i_cmd = cmd; i_peer_address = a; i_peer_port = p;
        i_packet_length = l; i_payload_handle = h; i_start = 1'b1;
        do @(posedge i_clk); while (o_busy);
        sb.note_item(cmd, a, p, l, h);
    endtask

    // burst/gap pacing of the command side
    task automatic pace();
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 3) != 0) begin
                @(negedge i_clk);
                i_start = 1'b0;
                repeat ($urandom_range(0, 6)) @(negedge i_clk);
            end
        end
        burst_left--;
    endtask

    task automatic rand_item(int queue_pct);
        logic [31:0] a;
        logic [15:0] p, l, h;
        a = $urandom; p = 16'($urandom); l = 16'($urandom); h = 16'($urandom);
        case ($urandom_range(0, 7))
            0: begin a = '0; p = '0; l = '0; h = '0; end
            1: begin a = '1; p = '1; l = '1; h = '1; end
            default: ;
        endcase
        pace();
        send_item($urandom_range(0, 99) >= queue_pct, a, p, l, h);
    endtask

    // let every pending result arrive, then cover a silent tick still in flight
    task automatic settle();
        @(negedge i_clk);
        i_start = 1'b0;
        do @(posedge i_clk); while (sb.expected_q.size() != 0 || o_busy);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [dlps_pkg::CFG_IDX_W-1:0] idx, logic [15:0] v);
        @(negedge i_clk);
        i_cfg_index = idx; i_cfg_data = v; i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, v);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_all(logic [15:0] mn, logic [15:0] mx, logic [15:0] ls,
                           logic [15:0] sd);
        write_reg(dlps_pkg::REG_MIN_LAT, mn);
        write_reg(dlps_pkg::REG_MAX_LAT, mx);
        write_reg(dlps_pkg::REG_LOSS_THR, ls);
        write_reg(dlps_pkg::REG_SEED, sd);
    endtask

    initial begin
        logic [15:0] mn, mx, ls;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: unknown index, zero seed, fill to refusal, drain
        write_reg(4'd9, 16'hFFFF);
        set_all(16'd0, 16'd0, 16'd0, 16'd0);
        for (int i = 0; i < 16; i++)
            send_item(1'b0, (i % 2) ? 32'hFFFF_FFFF : 32'h0, (i % 2) ? 16'hFFFF : 16'h0,
                      (i % 3 == 0) ? 16'h0 : 16'hFFFF, 16'(i));
        send_item(1'b0, 32'hDEAD_BEEF, 16'h1234, 16'h55AA, 16'hAA55);
        send_item(1'b1, '0, '0, '0, '0);
        send_item(1'b1, '1, '1, '1, '1);
        settle();
        write_reg(dlps_pkg::REG_LOSS_THR, 16'hFFFF);
        send_item(1'b0, 32'h0102_0304, 16'h8000, 16'h0001, 16'h8000);
        send_item(1'b0, 32'h8000_0000, 16'h0001, 16'h8000, 16'h0001);
        send_item(1'b1, '0, '0, '0, '0);
        settle();

        // random phases with short latencies
        for (int ph = 0; ph < 8; ph++) begin
            mn = 16'($urandom_range(0, 3));
            mx = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, mn))
                                             : mn + 16'($urandom_range(1, 10));
            case ($urandom_range(0, 3))
                0: ls = 16'h0;
                1: ls = 16'hFFFF;
                default: ls = 16'($urandom);
            endcase
            set_all(mn, mx, ls, ($urandom_range(0, 4) == 0) ? 16'h0 : 16'($urandom));
            for (int i = 0; i < 50; i++)
                rand_item(($urandom_range(0, 1) != 0) ? 50 : 35);
            settle();
        end

        // extremes last: long latencies leave the queue clogged
        set_all(16'd0, 16'hFFFF, 16'($urandom), 16'hFFFF);
        for (int i = 0; i < 30; i++) rand_item(60);
        settle();
        set_all(16'hFFFF, 16'hFFFF, 16'h0, 16'h0001);
        for (int i = 0; i < 30; i++) rand_item(60);
        settle();

        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("delay_loss_packet_scheduler_top: match");
        else
            $display("delay_loss_packet_scheduler_top: mismatch");
        $finish;
    end
endmodule
